FILE: rtl/core/max_prefix_sum_range_tree_top_assert.svh
// Assertion macros for the checker file of this block.
`ifndef MAX_PREFIX_SUM_RANGE_TREE_TOP_ASSERT_SVH
`define MAX_PREFIX_SUM_RANGE_TREE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPST_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mpst assertion failed");

// Next-cycle implication, checked outside reset.
`define MPST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mpst assertion failed");

`endif

FILE: rtl/core/mpst_pkg.sv
package mpst_pkg;

  localparam int PosW  = 10;
  localparam int ValW  = 32;
  localparam int BestW = 47;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_step;
    logic leaf_wr;
    logic ch_rd;
    logic node_wr;
    logic q_rd;
    logic q_join;
    logic out_load;
  } mpst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic wr_ok;
    logic skip;
    logic node_top;
    logic q_more;
  } mpst_sts_t;

endpackage

FILE: rtl/core/mpst_ctrl.sv
module mpst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mpst_pkg::mpst_sts_t sts_i,
  output mpst_pkg::mpst_cmd_t cmd_o
);
  import mpst_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StDecide, StWLeaf, StWRead, StWJoin, StQRead, StQJoin, StQFinal
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecide;
        end
      end
      StDecide: begin
        if (!sts_i.is_query) begin
          state_d = sts_i.wr_ok ? StWLeaf : StIdle;
        end else if (sts_i.skip || !sts_i.q_more) begin
          state_d = StQFinal;
        end else begin
          state_d = StQRead;
        end
      end
      StWLeaf: begin
        cmd_o.leaf_wr = 1'b1;
        state_d       = StWRead;
      end
      StWRead: begin
        cmd_o.ch_rd = 1'b1;
        state_d     = StWJoin;
      end
      StWJoin: begin
        cmd_o.node_wr = 1'b1;
        state_d       = sts_i.node_top ? StIdle : StWRead;
      end
      StQRead: begin
        cmd_o.q_rd = 1'b1;
        state_d    = StQJoin;
      end
      StQJoin: begin
        cmd_o.q_join = 1'b1;
        state_d      = sts_i.q_more ? StQRead : StQFinal;
      end
      StQFinal: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/mpst_dp.sv
module mpst_dp #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_i,
  input  logic [mpst_pkg::PosW-1:0]        position_i,
  input  logic [mpst_pkg::PosW-1:0]        range_end_i,
  input  logic signed [mpst_pkg::ValW-1:0] value_i,
  output logic [mpst_pkg::BestW-1:0]       best_prefix_o,
  input  mpst_pkg::mpst_cmd_t              ctl_i,
  output mpst_pkg::mpst_sts_t              sts_o
);
  import mpst_pkg::*;

  localparam int NodeCount = 2 * LEAF_COUNT;
  localparam int AW        = $clog2(NodeCount);
  localparam int RW        = $clog2(NodeCount + 1);
  localparam int SumW      = (ValW + 1 + $clog2(LEAF_COUNT) > 48) ?
                             (ValW + 1 + $clog2(LEAF_COUNT)) : 48;
  localparam int EW        = 2 * SumW;

  // Entry layout: {total, best}.
  function automatic logic [EW-1:0] join_f(input logic [EW-1:0] a, input logic [EW-1:0] b);
    logic signed [SumW-1:0] at, ab, bt, bb, s, t;
    at = a[EW-1:SumW];
    ab = a[SumW-1:0];
    bt = b[EW-1:SumW];
    bb = b[SumW-1:0];
    s  = at + bb;
    t  = at + bt;
    return {t, (ab > s) ? ab : s};
  endfunction

  logic [EW-1:0]   mem [NodeCount];
  logic [EW-1:0]   rda_q, rdb_q, acc_l_q, acc_r_q;
  logic [RW-1:0]   n_q, l_q, r_q, r_m1;
  logic [AW-1:0]   clr_q, ra, rb, wa;
  logic [EW-1:0]   wd, fin;
  logic            we;
  logic            is_query_q, wr_ok_q, skip_q, lodd_q, rodd_q;
  logic signed [SumW-1:0] v_q;
  logic [RW-1:0]   pos_ext, end_ext, end_sat;
  logic [BestW-1:0] best_q;

  assign pos_ext = RW'(position_i);
  assign end_ext = RW'(range_end_i);
  assign end_sat = (end_ext >= RW'(LEAF_COUNT)) ? RW'(LEAF_COUNT - 1) : end_ext;
  assign r_m1    = r_q - RW'(1);

  assign ra = ctl_i.q_rd ? l_q[AW-1:0]  : {n_q[AW-2:0], 1'b0};
  assign rb = ctl_i.q_rd ? r_m1[AW-1:0] : {n_q[AW-2:0], 1'b1};

  assign we = ctl_i.clr_step || ctl_i.leaf_wr || ctl_i.node_wr;
  assign wa = ctl_i.clr_step ? clr_q : n_q[AW-1:0];

  always_comb begin
    if (ctl_i.clr_step) begin
      wd = '0;
    end else if (ctl_i.leaf_wr) begin
      wd = {v_q, (v_q < 0) ? {SumW{1'b0}} : v_q};
    end else begin
      wd = join_f(rda_q, rdb_q);
    end
  end

  assign fin = join_f(acc_l_q, acc_r_q);

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rda_q <= mem[ra];
    rdb_q <= mem[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      is_query_q <= (cmd_i == CmdQuery);
      wr_ok_q    <= pos_ext < RW'(LEAF_COUNT);
      skip_q     <= (pos_ext >= RW'(LEAF_COUNT)) || (pos_ext > end_sat);
      v_q        <= SumW'(value_i);
      n_q        <= RW'(LEAF_COUNT) + pos_ext;
      l_q        <= RW'(LEAF_COUNT) + pos_ext;
      r_q        <= RW'(LEAF_COUNT) + end_sat + RW'(1);
      acc_l_q    <= '0;
      acc_r_q    <= '0;
    end
    if (ctl_i.leaf_wr || ctl_i.node_wr) n_q <= n_q >> 1;
    if (ctl_i.q_rd) begin
      lodd_q <= l_q[0];
      rodd_q <= r_q[0];
      l_q    <= (l_q + RW'(l_q[0])) >> 1;
      r_q    <= r_q >> 1;
    end
    if (ctl_i.q_join) begin
      if (lodd_q) acc_l_q <= join_f(acc_l_q, rda_q);
      if (rodd_q) acc_r_q <= join_f(rdb_q, acc_r_q);
    end
    if (ctl_i.out_load) begin
      best_q <= skip_q ? '0 : fin[BestW-1:0];
    end
  end

  assign best_prefix_o = best_q;

  assign sts_o.clr_last = (clr_q == AW'(NodeCount - 1));
  assign sts_o.is_query = is_query_q;
  assign sts_o.wr_ok    = wr_ok_q;
  assign sts_o.skip     = skip_q;
  assign sts_o.node_top = (n_q == RW'(1));
  assign sts_o.q_more   = (l_q < r_q);

endmodule

FILE: rtl/core/max_prefix_sum_range_tree_top.sv
// Write: the leaf is written, then the walk goes up level by level to the root.
// Query: a two-sided walk from the range ends goes up the tree level by level.
// One item is in work at a time; each tree level costs one memory read and one join.
// After reset the node store is swept to zero, with input stalled.
// The result register frees the input side: a new item is taken while a result waits.
module max_prefix_sum_range_tree_top #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [mpst_pkg::PosW-1:0]        position_i,
  input  logic [mpst_pkg::PosW-1:0]        range_end_i,
  input  logic signed [mpst_pkg::ValW-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mpst_pkg::BestW-1:0]       best_prefix_o
);
  import mpst_pkg::*;

  // The controller sequences the clearing sweep, the leaf-to-root update
  // walk and the two-sided query walk; the datapath owns the node memory,
  // the walk pointers and the join arithmetic.
  mpst_cmd_t cmd;
  mpst_sts_t sts;

  mpst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mpst_dp #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .position_i    (position_i),
    .range_end_i   (range_end_i),
    .value_i       (value_i),
    .best_prefix_o (best_prefix_o),
    .ctl_i         (cmd),
    .sts_o         (sts)
  );

endmodule

FILE: rtl/core/mpst_checker.sv
`include "max_prefix_sum_range_tree_top_assert.svh"

module mpst_assert_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [mpst_pkg::BestW-1:0]       best_prefix_o
);

  // A stalled result stays offered and unchanged.
  `MPST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(best_prefix_o))

  // Taking an item makes the block busy in the next cycle.
  `MPST_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A new result only comes out of a busy cycle.
  `MPST_ASSERT_NOW(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind max_prefix_sum_range_tree_top mpst_assert_checker u_mpst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .best_prefix_o (best_prefix_o)
);
